// ===== sv/lpht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, types and helpers of the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int SLOTS   = 16;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int ACT_W   = 2;
	localparam int KEY_W   = 31;
	localparam int NAME_W  = 64;
	localparam int MARKS_W = 16;
	localparam int STAT_W  = 2;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT  = 2'd0,
		ACT_REPLACE = 2'd1,
		ACT_SEARCH  = 2'd2,
		ACT_MODIFY  = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [NAME_W-1:0]  name;
		logic [MARKS_W-1:0] marks;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FREE_SCAN,
		S_KEY_SCAN,
		S_EVICT,
		S_RESP
	} state_t;

	typedef enum logic [2:0] {
		RES_PTR_OK,
		RES_HOME_OK,
		RES_FULL,
		RES_HIT_SEARCH,
		RES_HIT_MODIFY,
		RES_MISS
	} res_sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic     accept;
		logic     scan_step;
		logic     issue_read;
		logic     wr_new_ptr;
		logic     wr_res_ptr;
		logic     wr_new_home;
		logic     wr_mod_hit;
		logic     res_load;
		res_sel_t res_sel;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		action_t act;
		logic    req_lookup;
		logic    ptr_free;
		logic    scan_last;
		logic    at_home;
		logic    resident_home;
		logic    hit;
		logic    miss;
	} dp_stat_t;

	function automatic slot_t home_of(input logic [KEY_W-1:0] key);
		return SLOT_W'(key % SLOTS);
	endfunction

	function automatic slot_t next_slot(input slot_t s);
		return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

endpackage

// ===== sv/lpht_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_if
// Valid/ready channels for requests into and results out of the hash table.
// ----------------------------------------------------------------------------
interface lpht_req_if;
	logic                         valid;
	logic                         ready;
	logic [lpht_pkg::ACT_W-1:0]   action;
	logic [lpht_pkg::KEY_W-1:0]   key;
	logic [lpht_pkg::NAME_W-1:0]  name_code;
	logic [lpht_pkg::MARKS_W-1:0] marks;

	modport source (output valid, action, key, name_code, marks, input ready);
	modport sink (input valid, action, key, name_code, marks, output ready);
endinterface

interface lpht_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [lpht_pkg::STAT_W-1:0]  status;
	logic [lpht_pkg::SLOT_W-1:0]  slot;
	logic [lpht_pkg::NAME_W-1:0]  found_name;
	logic [lpht_pkg::MARKS_W-1:0] found_marks;

	modport source (output valid, status, slot, found_name, found_marks, input ready);
	modport sink (input valid, status, slot, found_name, found_marks, output ready);
endinterface

// ===== sv/lpht_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer of the hash table: walks probe scans and issues datapath commands.
// ----------------------------------------------------------------------------
module lpht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  lpht_pkg::dp_stat_t stat,
	output lpht_pkg::dp_cmd_t  cmd
);

	lpht_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpht_pkg::S_IDLE: begin
				// searches and modifies probe for a key, inserts and replaces for a free slot
				if (in_valid) begin
					if (stat.req_lookup) begin
						state_d = lpht_pkg::S_KEY_SCAN;
					end else begin
						state_d = lpht_pkg::S_FREE_SCAN;
					end
				end
			end
			lpht_pkg::S_FREE_SCAN: begin
				if (stat.ptr_free) begin
					if (stat.at_home || stat.act == lpht_pkg::ACT_INSERT ||
					    stat.resident_home) begin
						state_d = lpht_pkg::S_RESP;
					end else begin
						state_d = lpht_pkg::S_EVICT;
					end
				end else if (stat.scan_last) begin
					state_d = lpht_pkg::S_RESP;
				end
			end
			lpht_pkg::S_KEY_SCAN: begin
				if (stat.hit || stat.miss) begin
					state_d = lpht_pkg::S_RESP;
				end
			end
			lpht_pkg::S_EVICT: begin
				state_d = lpht_pkg::S_RESP;
			end
			lpht_pkg::S_RESP: begin
				if (out_ready) begin
					state_d = lpht_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lpht_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd         = '0;
		cmd.res_sel = lpht_pkg::RES_MISS;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		unique case (state_q)
			lpht_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			lpht_pkg::S_FREE_SCAN: begin
				if (stat.ptr_free) begin
					if (stat.at_home || stat.act == lpht_pkg::ACT_INSERT ||
					    stat.resident_home) begin
						cmd.wr_new_ptr = 1'b1;
						cmd.res_load   = 1'b1;
						cmd.res_sel    = lpht_pkg::RES_PTR_OK;
					end else begin
						cmd.wr_res_ptr = 1'b1;
					end
				end else if (stat.scan_last) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = lpht_pkg::RES_FULL;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			lpht_pkg::S_KEY_SCAN: begin
				cmd.issue_read = 1'b1;
				if (stat.hit) begin
					cmd.res_load = 1'b1;
					if (stat.act == lpht_pkg::ACT_SEARCH) begin
						cmd.res_sel = lpht_pkg::RES_HIT_SEARCH;
					end else begin
						cmd.wr_mod_hit = 1'b1;
						cmd.res_sel    = lpht_pkg::RES_HIT_MODIFY;
					end
				end else if (stat.miss) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = lpht_pkg::RES_MISS;
				end
			end
			lpht_pkg::S_EVICT: begin
				cmd.wr_new_home = 1'b1;
				cmd.res_load    = 1'b1;
				cmd.res_sel     = lpht_pkg::RES_HOME_OK;
			end
			lpht_pkg::S_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// a pending result holds until taken
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lpht_pkg::S_RESP && !out_ready |=> state_q == lpht_pkg::S_RESP)
		else $error("result dropped before transfer");

	// a result is loaded exactly when entering the response state
	a_res_on_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != lpht_pkg::S_RESP && state_d == lpht_pkg::S_RESP |-> cmd.res_load)
		else $error("response state entered without a result");

	// no request is taken while a result waits
	a_no_accept_in_resp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while a result waits");

endmodule

// ===== sv/lpht_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: record memory, occupancy flags, probe pointer and result registers.
// ----------------------------------------------------------------------------
module lpht_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lpht_pkg::dp_cmd_t            cmd,
	output lpht_pkg::dp_stat_t           stat,
	input  logic [lpht_pkg::ACT_W-1:0]   action,
	input  logic [lpht_pkg::KEY_W-1:0]   key,
	input  logic [lpht_pkg::NAME_W-1:0]  name_code,
	input  logic [lpht_pkg::MARKS_W-1:0] marks,
	output logic [lpht_pkg::STAT_W-1:0]  status,
	output logic [lpht_pkg::SLOT_W-1:0]  slot,
	output logic [lpht_pkg::NAME_W-1:0]  found_name,
	output logic [lpht_pkg::MARKS_W-1:0] found_marks
);

	// request registers
	lpht_pkg::action_t            act_q;
	logic [lpht_pkg::KEY_W-1:0]   key_q;
	logic [lpht_pkg::NAME_W-1:0]  name_q;
	logic [lpht_pkg::MARKS_W-1:0] marks_q;
	lpht_pkg::slot_t              home_q;

	// probe control
	lpht_pkg::slot_t              ptr_q;
	lpht_pkg::cnt_t               cnt_q;
	logic [lpht_pkg::SLOTS-1:0]   occupied_q;

	// record memory and its read stage
	lpht_pkg::entry_t             mem [lpht_pkg::SLOTS];
	lpht_pkg::entry_t             rd_data_s1;
	lpht_pkg::slot_t              addr_s1;
	logic                         valid_s1;
	logic                         last_s1;

	// result registers
	lpht_pkg::status_t            res_status_q;
	lpht_pkg::slot_t              res_slot_q;
	logic [lpht_pkg::NAME_W-1:0]  res_name_q;
	logic [lpht_pkg::MARKS_W-1:0] res_marks_q;

	lpht_pkg::slot_t              in_home;
	logic                         key_issue;
	logic                         rd_en;
	lpht_pkg::slot_t              rd_addr;
	logic                         wr_en;
	lpht_pkg::slot_t              wr_addr;
	lpht_pkg::entry_t             wr_data;
	lpht_pkg::entry_t             new_entry;
	logic                         hit;

	assign in_home   = lpht_pkg::home_of(key);
	assign key_issue = cmd.issue_read && (cnt_q < lpht_pkg::CNT_W'(lpht_pkg::SLOTS));
	assign new_entry = '{key: key_q, name: name_q, marks: marks_q};

	// read port: home slot on accept, then one key probe per cycle
	assign rd_en   = cmd.accept || key_issue;
	assign rd_addr = cmd.accept ? in_home : ptr_q;

	// write port
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = ptr_q;
		wr_data = new_entry;
		if (cmd.wr_new_ptr) begin
			wr_addr = ptr_q;
		end else if (cmd.wr_res_ptr) begin
			wr_data = rd_data_s1;
		end else if (cmd.wr_new_home) begin
			wr_addr = home_q;
		end else if (cmd.wr_mod_hit) begin
			wr_addr = addr_s1;
		end else begin
			wr_en = 1'b0;
		end
	end

	// record memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q   <= lpht_pkg::action_t'(action);
			key_q   <= key;
			name_q  <= name_code;
			marks_q <= marks;
			home_q  <= in_home;
		end
	end

	// probe pointer, counter, read stage tracking and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			cnt_q      <= '0;
			addr_s1    <= '0;
			valid_s1   <= 1'b0;
			last_s1    <= 1'b0;
			occupied_q <= '0;
		end else begin
			valid_s1 <= 1'b0;
			if (cmd.accept) begin
				addr_s1  <= in_home;
				valid_s1 <= 1'b1;
				last_s1  <= 1'b0;
				if (action == lpht_pkg::ACT_SEARCH || action == lpht_pkg::ACT_MODIFY) begin
					// home is read now, the scan continues after it
					ptr_q <= lpht_pkg::next_slot(in_home);
					cnt_q <= lpht_pkg::CNT_W'(1);
				end else begin
					ptr_q <= in_home;
					cnt_q <= '0;
				end
			end else if (cmd.scan_step) begin
				ptr_q <= lpht_pkg::next_slot(ptr_q);
				cnt_q <= cnt_q + 1'b1;
			end else if (key_issue) begin
				addr_s1  <= ptr_q;
				valid_s1 <= 1'b1;
				last_s1  <= (cnt_q == lpht_pkg::CNT_W'(lpht_pkg::SLOTS - 1));
				ptr_q    <= lpht_pkg::next_slot(ptr_q);
				cnt_q    <= cnt_q + 1'b1;
			end
			if (wr_en) begin
				occupied_q[wr_addr] <= 1'b1;
			end
		end
	end

	// status toward the controller
	assign hit = valid_s1 && occupied_q[addr_s1] && (rd_data_s1.key == key_q);

	always_comb begin
		stat.act           = act_q;
		stat.req_lookup    = (action == lpht_pkg::ACT_SEARCH) ||
		                     (action == lpht_pkg::ACT_MODIFY);
		stat.ptr_free      = !occupied_q[ptr_q];
		stat.scan_last     = (cnt_q == lpht_pkg::CNT_W'(lpht_pkg::SLOTS - 1));
		stat.at_home       = (ptr_q == home_q);
		stat.resident_home = (lpht_pkg::home_of(rd_data_s1.key) == home_q);
		stat.hit           = hit;
		stat.miss          = valid_s1 && last_s1 && !hit;
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= lpht_pkg::ST_OK;
			res_slot_q   <= '0;
			res_name_q   <= '0;
			res_marks_q  <= '0;
			case (cmd.res_sel)
				lpht_pkg::RES_PTR_OK: begin
					res_slot_q <= ptr_q;
				end
				lpht_pkg::RES_HOME_OK: begin
					res_slot_q <= home_q;
				end
				lpht_pkg::RES_FULL: begin
					res_status_q <= lpht_pkg::ST_FULL;
				end
				lpht_pkg::RES_HIT_SEARCH: begin
					res_slot_q  <= addr_s1;
					res_name_q  <= rd_data_s1.name;
					res_marks_q <= rd_data_s1.marks;
				end
				lpht_pkg::RES_HIT_MODIFY: begin
					res_slot_q <= addr_s1;
				end
				default: begin
					res_status_q <= lpht_pkg::ST_MISS;
				end
			endcase
		end
	end

	assign status      = res_status_q;
	assign slot        = res_slot_q;
	assign found_name  = res_name_q;
	assign found_marks = res_marks_q;

	// written slots become occupied
	a_wr_occupies: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> occupied_q[$past(wr_addr)])
		else $error("written slot not marked occupied");

	// nothing is ever deleted
	a_occ_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (($past(occupied_q) & ~occupied_q) == '0))
		else $error("occupied flag cleared");

	// a successful result always names an occupied slot
	a_ok_slot_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> (res_status_q != lpht_pkg::ST_OK) || occupied_q[res_slot_q])
		else $error("successful result names an empty slot");

endmodule

// ===== sv/linear_probe_hash_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Sixteen-slot linear probing hash table with insert, replace, search, modify.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | action, key, name_code, marks
//  rsp     | out | valid/ready | status, slot, found_name, found_marks
//
//  One request at a time. Inserts and replaces walk the occupancy flags one
//  slot per cycle from home, plus an evict step when a resident is evicted.
//  Search and modify read one record per cycle through the single memory
//  read port. Each item is accepted in idle and answered from the result
//  state. Reset empties the table at once; the result waits in its register
//  until rsp is ready, and req is not taken meanwhile.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core (
	input  logic      clk,
	input  logic      arst_n,
	lpht_req_if.sink  req,
	lpht_rsp_if.source rsp
);

	lpht_pkg::dp_cmd_t  cmd;
	lpht_pkg::dp_stat_t stat;
	logic               in_ready;
	logic               out_valid;

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

	// sequencer
	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage and probe datapath
	lpht_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (req.action),
		.key         (req.key),
		.name_code   (req.name_code),
		.marks       (req.marks),
		.status      (rsp.status),
		.slot        (rsp.slot),
		.found_name  (rsp.found_name),
		.found_marks (rsp.found_marks)
	);

endmodule
